// ===== rtl/equirect_geo_distance_top_macros.svh =====
// assertion macros for the equirectangular distance block
`ifndef EQUIRECT_GEO_DISTANCE_TOP_MACROS_SVH
`define EQUIRECT_GEO_DISTANCE_TOP_MACROS_SVH

`ifndef SYNTHESIS
// condition that must hold on every cycle out of reset
`define EGD_ASSERT(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("egd assertion failed");
// implication checked on every cycle out of reset
`define EGD_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("egd assertion failed");
`else
`define EGD_ASSERT(lbl, expr)
`define EGD_ASSERT_IMP(lbl, ante, cons)
`endif

`endif

// ===== rtl/egd_pkg.sv =====
// shared types and fixed-point constants for the distance pipeline
`default_nettype none

package egd_pkg;

  localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;
  localparam logic [63:0] PI_Q31 = PI_Q60 >> 29;

  // radians per half-microdegree, Q62
  localparam logic [35:0] ANG_Q62 = 36'(PI_Q60 / 64'd90000000);
  localparam logic [17:0] ANG_HI  = ANG_Q62[35:18];
  localparam logic [17:0] ANG_LO  = ANG_Q62[17:0];

  // decimetres per microdegree, Q31
  localparam logic [31:0] SCALE_Q31 = 32'((PI_Q31 * 64'd339786 +
      (PI_Q31 * 64'd707808) / 64'd1000000) / 64'd1000000);

  localparam logic [31:0] ONE_Q31   = 32'h8000_0000;
  localparam logic [30:0] ONE_Q30   = 31'h4000_0000;
  localparam logic [28:0] DIST_MAX  = 29'h1FFF_FFFF;

  localparam logic [28:0] FULL_TURN = 29'd360000000;
  localparam logic [28:0] HALF_TURN = 29'd180000000;
  localparam logic [28:0] QTR_TURN  = 29'd90000000;

  localparam int unsigned HORNER_STEPS = 5;
  localparam int unsigned SQRT_STEPS   = 32;

  // reciprocal constants: floor(p / d) == (p * m) >> k for p < 2^31
  localparam logic [32:0] COS_M [HORNER_STEPS] = '{
    33'(((64'd1 << 38) + 64'd89) / 64'd90),
    33'(((64'd1 << 37) + 64'd55) / 64'd56),
    33'(((64'd1 << 36) + 64'd29) / 64'd30),
    33'(((64'd1 << 35) + 64'd11) / 64'd12),
    33'(((64'd1 << 32) + 64'd1) / 64'd2)
  };
  localparam int unsigned COS_K [HORNER_STEPS] = '{38, 37, 36, 35, 32};

  localparam logic [32:0] SIN_M [HORNER_STEPS] = '{
    33'(((64'd1 << 38) + 64'd109) / 64'd110),
    33'(((64'd1 << 38) + 64'd71) / 64'd72),
    33'(((64'd1 << 37) + 64'd41) / 64'd42),
    33'(((64'd1 << 36) + 64'd19) / 64'd20),
    33'(((64'd1 << 34) + 64'd5) / 64'd6)
  };
  localparam int unsigned SIN_K [HORNER_STEPS] = '{38, 38, 37, 36, 34};

  // data that rides along the series cells
  typedef struct packed {
    logic        use_sin;
    logic [30:0] r;
    logic [30:0] x2;
    logic [28:0] dlon;
    logic [27:0] dlat;
  } egd_cos_t;

  // partial remainder and root of the square root chain
  typedef struct packed {
    logic [63:0] rem;
    logic [63:0] res;
  } egd_sqrt_t;

endpackage

`default_nettype wire

// ===== rtl/egd_horner_cell.sv =====
// one horner step of the cosine / sine series, two register stages
`default_nettype none

module egd_horner_cell #(
  parameter int unsigned STEP = 0
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_vld,
  input  wire egd_pkg::egd_cos_t in_side,
  input  wire logic [31:0]      in_acc,
  output logic                  out_vld,
  output egd_pkg::egd_cos_t     out_side,
  output logic [31:0]           out_acc
);
  import egd_pkg::*;

  logic        vld_a_r;
  egd_cos_t    side_a_r;
  logic [30:0] p_a_r;
  logic [62:0] prod_a;
  logic [32:0] m_sel;
  logic [63:0] prod_b;
  logic [30:0] q_b;
  logic [31:0] acc_nxt;
  logic        vld_b_r;
  egd_cos_t    side_b_r;
  logic [31:0] acc_b_r;

  // x2 * acc, truncated to q31
  assign prod_a = 63'(in_side.x2) * 63'(in_acc);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_a_r <= 1'b0;
      vld_b_r <= 1'b0;
    end else begin
      vld_a_r <= in_vld;
      vld_b_r <= vld_a_r;
    end
  end

  always_ff @(posedge clk) begin
    side_a_r <= in_side;
    p_a_r    <= prod_a[61:31];
    side_b_r <= side_a_r;
    acc_b_r  <= acc_nxt;
  end

  // divide by the series constant through its reciprocal
  always_comb begin
    m_sel   = side_a_r.use_sin ? SIN_M[STEP] : COS_M[STEP];
    prod_b  = 64'(p_a_r) * 64'(m_sel);
    q_b     = side_a_r.use_sin ? 31'(prod_b >> SIN_K[STEP]) : 31'(prod_b >> COS_K[STEP]);
    acc_nxt = ONE_Q31 - 32'(q_b);
  end

  assign out_vld  = vld_b_r;
  assign out_side = side_b_r;
  assign out_acc  = acc_b_r;

endmodule

`default_nettype wire

// ===== rtl/egd_sqrt_cell.sv =====
// one result bit of the restoring integer square root
`default_nettype none

module egd_sqrt_cell #(
  parameter int unsigned STEP = 0
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_vld,
  input  wire egd_pkg::egd_sqrt_t in_sq,
  output logic                   out_vld,
  output egd_pkg::egd_sqrt_t     out_sq
);
  import egd_pkg::*;

  localparam logic [63:0] BIT = 64'd1 << (62 - 2 * STEP);

  logic [63:0] trial;
  logic        take;
  egd_sqrt_t   sq_nxt;
  logic        vld_r;
  egd_sqrt_t   sq_r;

  always_comb begin
    trial      = in_sq.res + BIT;
    take       = in_sq.rem >= trial;
    sq_nxt.rem = take ? in_sq.rem - trial : in_sq.rem;
    sq_nxt.res = take ? (in_sq.res >> 1) + BIT : in_sq.res >> 1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    sq_r <= sq_nxt;
  end

  assign out_vld = vld_r;
  assign out_sq  = sq_r;

endmodule

`default_nettype wire

// ===== rtl/equirect_geo_distance_top.sv =====
// equirectangular ground distance between two points, fully pipelined
`default_nettype none
`include "equirect_geo_distance_top_macros.svh"

// usage
//   request channel: drive the four coordinates (signed microdegrees) and
//   raise start; a request is taken at every rising edge with start high
//   and busy low. busy is held low, so a new request may enter every cycle.
//   result channel: out_valid is high for exactly one cycle with
//   out_distance_dm (decimetres, floored, saturated at 2^29-1). the
//   receiver cannot stall, and nothing here waits on it.
//   throughput is one request per cycle. the pipeline depth is set by the
//   chain: angle fold and conversion, five horner cells of two stages each
//   for the cosine or sine, the dlon product and squares, and 32 square root
//   cells of one result bit each, then the scale and saturate stages.
//   results leave in request order, one per request.
//   reset (synchronous, active low) clears every stage valid bit, so
//   requests in flight are dropped and no strobe follows; data registers
//   are not reset.

module equirect_geo_distance_top (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic signed [28:0] in_lon_a,
  input  wire logic signed [27:0] in_lat_a,
  input  wire logic signed [28:0] in_lon_b,
  input  wire logic signed [27:0] in_lat_b,
  output logic                    out_valid,
  output logic [28:0]             out_distance_dm
);
  import egd_pkg::*;

  // request handshake
  logic accept;
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // differences and mean latitude magnitude
  logic signed [29:0] lon_d;
  logic signed [28:0] lat_d;
  logic signed [28:0] lat_s;
  logic [29:0]        lon_abs;
  logic [28:0]        lat_abs;
  logic [28:0]        sum_abs;

  always_comb begin
    lon_d   = 30'(in_lon_a) - 30'(in_lon_b);
    lat_d   = 29'(in_lat_a) - 29'(in_lat_b);
    lat_s   = 29'(in_lat_a) + 29'(in_lat_b);
    lon_abs = lon_d[29] ? 30'(-lon_d) : 30'(lon_d);
    lat_abs = lat_d[28] ? 29'(-lat_d) : 29'(lat_d);
    sum_abs = lat_s[28] ? 29'(-lat_s) : 29'(lat_s);
  end

  // stage 1: input register
  logic        s1_vld_r;
  logic [28:0] s1_dlon_r;
  logic [27:0] s1_dlat_r;
  logic [28:0] s1_h_r;

  // stage 2: fold the angle into the first octant
  logic [28:0] h1;
  logic        fold_sin;
  logic [28:0] h2;
  logic        s2_vld_r;
  logic        s2_sin_r;
  logic [26:0] s2_h_r;
  logic [28:0] s2_dlon_r;
  logic [27:0] s2_dlat_r;

  always_comb begin
    h1       = (s1_h_r > HALF_TURN) ? FULL_TURN - s1_h_r : s1_h_r;
    fold_sin = h1 > QTR_TURN;
    h2       = fold_sin ? HALF_TURN - h1 : h1;
  end

  // stage 3: half-microdegrees to radians, split in two partial products
  logic        s3_vld_r;
  logic        s3_sin_r;
  logic [44:0] s3_pp_hi_r;
  logic [44:0] s3_pp_lo_r;
  logic [28:0] s3_dlon_r;
  logic [27:0] s3_dlat_r;

  // stage 4: sum and round to q31
  logic [63:0] r_sum;
  logic        s4_vld_r;
  logic        s4_sin_r;
  logic [30:0] s4_r_r;
  logic [28:0] s4_dlon_r;
  logic [27:0] s4_dlat_r;

  assign r_sum = (64'(s3_pp_hi_r) << 18) + 64'(s3_pp_lo_r) + (64'd1 << 30);

  // stage 5: r squared, start of the series chain
  logic [61:0] r_sq;
  logic        s5_vld_r;
  egd_cos_t    s5_side_r;

  assign r_sq = 62'(s4_r_r) * 62'(s4_r_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
      s4_vld_r <= 1'b0;
      s5_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= accept;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
      s4_vld_r <= s3_vld_r;
      s5_vld_r <= s4_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_dlon_r <= lon_abs[28:0];
    s1_dlat_r <= lat_abs[27:0];
    s1_h_r    <= sum_abs;

    s2_sin_r  <= fold_sin;
    s2_h_r    <= h2[26:0];
    s2_dlon_r <= s1_dlon_r;
    s2_dlat_r <= s1_dlat_r;

    s3_sin_r   <= s2_sin_r;
    s3_pp_hi_r <= 45'(s2_h_r) * 45'(ANG_HI);
    s3_pp_lo_r <= 45'(s2_h_r) * 45'(ANG_LO);
    s3_dlon_r  <= s2_dlon_r;
    s3_dlat_r  <= s2_dlat_r;

    s4_sin_r  <= s3_sin_r;
    s4_r_r    <= r_sum[61:31];
    s4_dlon_r <= s3_dlon_r;
    s4_dlat_r <= s3_dlat_r;

    s5_side_r.use_sin <= s4_sin_r;
    s5_side_r.r       <= s4_r_r;
    s5_side_r.x2      <= r_sq[61:31];
    s5_side_r.dlon    <= s4_dlon_r;
    s5_side_r.dlat    <= s4_dlat_r;
  end

  // series chain: five horner cells
  logic        hc_vld  [HORNER_STEPS+1];
  egd_cos_t    hc_side [HORNER_STEPS+1];
  logic [31:0] hc_acc  [HORNER_STEPS+1];

  assign hc_vld[0]  = s5_vld_r;
  assign hc_side[0] = s5_side_r;
  assign hc_acc[0]  = ONE_Q31;

  for (genvar gi = 0; gi < HORNER_STEPS; gi++) begin : g_horner
    egd_horner_cell #(
      .STEP (gi)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .in_vld   (hc_vld[gi]),
      .in_side  (hc_side[gi]),
      .in_acc   (hc_acc[gi]),
      .out_vld  (hc_vld[gi+1]),
      .out_side (hc_side[gi+1]),
      .out_acc  (hc_acc[gi+1])
    );
  end

  // stage 16: sine needs a final multiply by r
  logic [62:0] sin_prod;
  logic        s16_vld_r;
  logic        s16_sin_r;
  logic [31:0] s16_vs_r;
  logic [31:0] s16_acc_r;
  logic [28:0] s16_dlon_r;
  logic [27:0] s16_dlat_r;

  assign sin_prod = 63'(hc_side[HORNER_STEPS].r) * 63'(hc_acc[HORNER_STEPS]);

  // stage 17: round to q30 and clamp at one
  logic [31:0] v_sel;
  logic [32:0] v_rnd;
  logic [30:0] c_nxt;
  logic        s17_vld_r;
  logic [30:0] s17_c_r;
  logic [28:0] s17_dlon_r;
  logic [27:0] s17_dlat_r;

  always_comb begin
    v_sel = s16_sin_r ? s16_vs_r : s16_acc_r;
    v_rnd = (33'(v_sel) + 33'd1) >> 1;
    c_nxt = (v_rnd > 33'(ONE_Q30)) ? ONE_Q30 : v_rnd[30:0];
  end

  // stage 18: cos * dlon
  logic        s18_vld_r;
  logic [59:0] s18_cx_r;
  logic [27:0] s18_dlat_r;

  // stage 19: round to quarter microdegrees and square both legs
  logic [60:0] x_rnd;
  logic [31:0] xq;
  logic [29:0] yq;
  logic        s19_vld_r;
  logic [63:0] s19_xsq_r;
  logic [59:0] s19_ysq_r;

  always_comb begin
    x_rnd = 61'(s18_cx_r) + (61'd1 << 27);
    xq    = x_rnd[59:28];
    yq    = {s18_dlat_r, 2'b00};
  end

  // stage 20: sum of squares, head of the root chain
  logic      s20_vld_r;
  egd_sqrt_t s20_sq_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s16_vld_r <= 1'b0;
      s17_vld_r <= 1'b0;
      s18_vld_r <= 1'b0;
      s19_vld_r <= 1'b0;
      s20_vld_r <= 1'b0;
    end else begin
      s16_vld_r <= hc_vld[HORNER_STEPS];
      s17_vld_r <= s16_vld_r;
      s18_vld_r <= s17_vld_r;
      s19_vld_r <= s18_vld_r;
      s20_vld_r <= s19_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s16_sin_r  <= hc_side[HORNER_STEPS].use_sin;
    s16_vs_r   <= sin_prod[62:31];
    s16_acc_r  <= hc_acc[HORNER_STEPS];
    s16_dlon_r <= hc_side[HORNER_STEPS].dlon;
    s16_dlat_r <= hc_side[HORNER_STEPS].dlat;

    s17_c_r    <= c_nxt;
    s17_dlon_r <= s16_dlon_r;
    s17_dlat_r <= s16_dlat_r;

    s18_cx_r   <= 60'(s17_c_r) * 60'(s17_dlon_r);
    s18_dlat_r <= s17_dlat_r;

    s19_xsq_r  <= 64'(xq) * 64'(xq);
    s19_ysq_r  <= 60'(yq) * 60'(yq);

    s20_sq_r.rem <= s19_xsq_r + 64'(s19_ysq_r);
    s20_sq_r.res <= 64'd0;
  end

  // root chain: one cell per result bit
  logic      sq_vld   [SQRT_STEPS+1];
  egd_sqrt_t sq_chain [SQRT_STEPS+1];

  assign sq_vld[0]   = s20_vld_r;
  assign sq_chain[0] = s20_sq_r;

  for (genvar gj = 0; gj < SQRT_STEPS; gj++) begin : g_sqrt
    egd_sqrt_cell #(
      .STEP (gj)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .in_vld  (sq_vld[gj]),
      .in_sq   (sq_chain[gj]),
      .out_vld (sq_vld[gj+1]),
      .out_sq  (sq_chain[gj+1])
    );
  end

  // scale to decimetres, then saturate
  logic        sc_vld_r;
  logic [63:0] sc_prod_r;
  logic [30:0] dist_raw;
  logic        out_vld_r;
  logic [28:0] out_dist_r;

  assign dist_raw = sc_prod_r[63:33];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sc_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      sc_vld_r  <= sq_vld[SQRT_STEPS];
      out_vld_r <= sc_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    sc_prod_r  <= 64'(sq_chain[SQRT_STEPS].res[31:0]) * 64'(SCALE_Q31);
    out_dist_r <= (dist_raw > 31'(DIST_MAX)) ? DIST_MAX : dist_raw[28:0];
  end

  assign out_valid       = out_vld_r;
  assign out_distance_dm = out_dist_r;

  // series accumulator stays in (0, 1]
  `EGD_ASSERT_IMP(a_horner_acc, hc_vld[HORNER_STEPS], (hc_acc[HORNER_STEPS] <= ONE_Q31) && (hc_acc[HORNER_STEPS] != 32'd0))
  // cosine never exceeds one after rounding
  `EGD_ASSERT_IMP(a_cos_clamp, s17_vld_r, s17_c_r <= ONE_Q30)
  // floor root: remainder is at most twice the root
  `EGD_ASSERT_IMP(a_sqrt_floor, sq_vld[SQRT_STEPS], sq_chain[SQRT_STEPS].rem <= (sq_chain[SQRT_STEPS].res << 1))

endmodule

`default_nettype wire

// ===== dv/equirect_geo_distance_checker.sv =====
// checker for the distance block: predicts each request's distance and compares results
`timescale 1ns / 1ps
`default_nettype none

module equirect_geo_distance_checker (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic               busy,
  input  wire logic signed [28:0] in_lon_a,
  input  wire logic signed [27:0] in_lat_a,
  input  wire logic signed [28:0] in_lon_b,
  input  wire logic signed [27:0] in_lat_b,
  input  wire logic               out_valid,
  input  wire logic [28:0]        out_distance_dm,
  output int                      fail_count,
  output int                      pending_count
);

  localparam longint unsigned PI_Q60    = 64'h3243F6A8885A308D;
  localparam longint unsigned PI_Q31    = PI_Q60 >> 29;
  localparam longint unsigned ANG_Q62   = PI_Q60 / 64'd90000000;
  localparam longint unsigned SCALE_Q31 = (PI_Q31 * 64'd339786 +
      (PI_Q31 * 64'd707808) / 64'd1000000) / 64'd1000000;
  localparam longint unsigned ONE_Q31   = 64'd1 << 31;
  localparam longint unsigned DIST_MAX  = (64'd1 << 29) - 64'd1;

  logic [28:0] distance_queue [$];

  function automatic longint unsigned mul_q31(longint unsigned a, longint unsigned b);
    return (a * b) >> 31;
  endfunction

  // |cos| of the mean latitude, h in half-microdegrees, result q1.30
  function automatic longint unsigned mean_lat_cos(longint unsigned h_in);
    longint unsigned cdiv [5] = '{90, 56, 30, 12, 2};
    longint unsigned sdiv [5] = '{110, 72, 42, 20, 6};
    longint unsigned h, r, x2, acc;
    logic use_sin;
    h = h_in;
    use_sin = 1'b0;
    if (h > 64'd180000000) h = 64'd360000000 - h;
    if (h > 64'd90000000) begin
      h = 64'd180000000 - h;
      use_sin = 1'b1;
    end
    r = (h * ANG_Q62 + (64'd1 << 30)) >> 31;
    x2 = mul_q31(r, r);
    acc = ONE_Q31;
    for (int k = 0; k < 5; k++)
      acc = ONE_Q31 - mul_q31(x2, acc) / (use_sin ? sdiv[k] : cdiv[k]);
    if (use_sin) acc = mul_q31(r, acc);
    acc = (acc + 1) >> 1;
    if (acc > (64'd1 << 30)) acc = 64'd1 << 30;
    return acc;
  endfunction

  function automatic longint unsigned floor_sqrt(longint unsigned n_in);
    longint unsigned n, res, bit_w;
    n = n_in;
    res = 0;
    bit_w = 64'd1 << 62;
    while (bit_w > n) bit_w >>= 2;
    while (bit_w != 0) begin
      if (n >= res + bit_w) begin
        n -= res + bit_w;
        res = (res >> 1) + bit_w;
      end else begin
        res >>= 1;
      end
      bit_w >>= 2;
    end
    return res;
  endfunction

  function automatic logic [28:0] geo_distance(longint lon_a, longint lat_a,
                                               longint lon_b, longint lat_b);
    longint dx, dy, sum;
    longint unsigned dlon, dlat, h, c, xq, yq, root, dist_v;
    dx = lon_a - lon_b;
    dy = lat_a - lat_b;
    sum = lat_a + lat_b;
    dlon = dx < 0 ? -dx : dx;
    dlat = dy < 0 ? -dy : dy;
    h = sum < 0 ? -sum : sum;
    c = mean_lat_cos(h);
    xq = (c * dlon + (64'd1 << 27)) >> 28;
    yq = dlat << 2;
    root = floor_sqrt(xq * xq + yq * yq);
    dist_v = (root * SCALE_Q31) >> 33;
    if (dist_v > DIST_MAX) dist_v = DIST_MAX;
    return dist_v[28:0];
  endfunction

  assign pending_count = distance_queue.size();

  always @(posedge clk) begin
    logic [28:0] want;
    if (rst_n) begin
      if (start && !busy)
        distance_queue.push_back(geo_distance(in_lon_a, in_lat_a, in_lon_b, in_lat_b));
      if (out_valid) begin
        if (distance_queue.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %0d", $time,
                   out_distance_dm);
          fail_count++;
        end else begin
          want = distance_queue.pop_front();
          if (want !== out_distance_dm) begin
            $display("%0t: distance_dm mismatch, expected %0d, actual %0d", $time,
                     want, out_distance_dm);
            fail_count++;
          end
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
// top of the distance block testbench: clock, reset, request stimulus and verdict
`timescale 1ns / 1ps
`default_nettype none

module testbench;

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic signed [28:0] lon_a, lon_b;
  logic signed [27:0] lat_a, lat_b;
  logic               out_valid;
  logic [28:0]        out_distance_dm;
  int                 fail_count;
  int                 pending_count;

  equirect_geo_distance_top u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_lon_a       (lon_a),
    .in_lat_a       (lat_a),
    .in_lon_b       (lon_b),
    .in_lat_b       (lat_b),
    .out_valid      (out_valid),
    .out_distance_dm(out_distance_dm)
  );

  equirect_geo_distance_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_lon_a       (lon_a),
    .in_lat_a       (lat_a),
    .in_lon_b       (lon_b),
    .in_lat_b       (lat_b),
    .out_valid      (out_valid),
    .out_distance_dm(out_distance_dm),
    .fail_count     (fail_count),
    .pending_count  (pending_count)
  );

  // 20 ns clock
  initial clk = 1'b0;
  always #10 clk = ~clk;

  localparam int DRAIN_CYCLES = 80;

  // drive one request at the falling edge and hold it until taken;
  // busy only moves at rising edges, so its value here is what the next edge sees
  task automatic send_request(logic signed [28:0] la_lon, logic signed [27:0] la_lat,
                              logic signed [28:0] lb_lon, logic signed [27:0] lb_lat);
    start <= 1'b1;
    lon_a <= la_lon;
    lat_a <= la_lat;
    lon_b <= lb_lon;
    lat_b <= lb_lat;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
  endtask

  // lower start for a gap of idle cycles
  task automatic idle_gap(int cycles);
    if (cycles > 0) begin
      start <= 1'b0;
      repeat (cycles) @(negedge clk);
    end
  endtask

  // random signed value in a range
  function automatic longint rand_span(longint lo, longint hi);
    return lo + longint'($urandom_range(32'(hi - lo), 0));
  endfunction

  initial begin
    longint a_lon, a_lat, b_lon, b_lat;
    int burst, mode;
    rst_n = 1'b0;
    start = 1'b0;
    lon_a = '0;
    lat_a = '0;
    lon_b = '0;
    lat_b = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: zero distance, range extremes, octant edges, folds and saturation
    send_request(29'sd0, 28'sd0, 29'sd0, 28'sd0);
    send_request(-29'sd180000000, 28'sd0, 29'sd180000000, 28'sd0);
    send_request(29'sd0, -28'sd90000000, 29'sd0, 28'sd90000000);
    send_request(-29'sd180000000, -28'sd90000000, 29'sd180000000, 28'sd90000000);
    send_request(29'sd180000000, 28'sd90000000, -29'sd180000000, 28'sd90000000);
    send_request(29'sd180000000, -28'sd90000000, -29'sd180000000, -28'sd90000000);
    // mean latitude exactly at 45 degrees and one step past
    send_request(29'sd0, 28'sd45000000, 29'sd1000000, 28'sd45000000);
    send_request(29'sd0, 28'sd45000000, 29'sd1000000, 28'sd45000001);
    send_request(29'sd5, -28'sd45000000, -29'sd5, -28'sd45000001);
    // mean latitude near and beyond 90 degrees from out-of-range patterns
    send_request(29'sd0, 28'sd89999999, 29'sd100000, 28'sd90000000);
    send_request(29'sd0, 28'sd134217727, 29'sd1000000, 28'sd134217727);
    send_request(29'sd0, -28'sd134217728, 29'sd1000000, -28'sd134217728);
    send_request(29'sd1, 28'sd100000000, -29'sd1, 28'sd95000000);
    // widest longitude patterns, saturating the distance
    send_request(-29'sd268435456, 28'sd0, 29'sd268435455, 28'sd0);
    send_request(29'sd268435455, -28'sd134217728, -29'sd268435456, 28'sd134217727);
    send_request(29'sd268435455, 28'sd0, -29'sd268435456, 28'sd1);
    // tiny steps and back-to-back requests
    send_request(29'sd1, 28'sd0, 29'sd0, 28'sd0);
    send_request(29'sd0, 28'sd1, 29'sd0, 28'sd0);
    send_request(-29'sd1, -28'sd1, 29'sd0, 28'sd0);
    send_request(29'sd12345678, 28'sd48000000, 29'sd12400000, 28'sd48100000);
    idle_gap(3);

    // pause until the pipeline has drained completely
    while (pending_count != 0) @(negedge clk);

    // random: bursts of requests with random gaps, some without gaps
    for (int n = 0; n < 1300; ) begin
      burst = $urandom_range(40, 1);
      for (int k = 0; k < burst; k++) begin
        mode = $urandom_range(9, 0);
        if (mode < 6) begin
          // in-range points anywhere on the globe
          a_lon = rand_span(-180000000, 180000000);
          a_lat = rand_span(-90000000, 90000000);
          b_lon = rand_span(-180000000, 180000000);
          b_lat = rand_span(-90000000, 90000000);
        end else if (mode < 8) begin
          // short edges, typical of road graphs
          a_lon = rand_span(-180000000, 180000000);
          a_lat = rand_span(-90000000, 90000000);
          b_lon = a_lon + rand_span(-50000, 50000);
          b_lat = a_lat + rand_span(-50000, 50000);
          if (b_lat > 90000000) b_lat = 90000000;
          if (b_lat < -90000000) b_lat = -90000000;
        end else begin
          // any field pattern
          a_lon = rand_span(-268435456, 268435455);
          a_lat = rand_span(-134217728, 134217727);
          b_lon = rand_span(-268435456, 268435455);
          b_lat = rand_span(-134217728, 134217727);
        end
        send_request(29'(a_lon), 28'(a_lat), 29'(b_lon), 28'(b_lat));
        n++;
      end
      if ($urandom_range(3, 0) != 0) idle_gap($urandom_range(12, 1));
    end
    start <= 1'b0;

    // drain and let any stray strobe show up
    while (pending_count != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0 && pending_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // watchdog, far beyond the slowest correct run
  initial begin
    #4ms;
    $display("== FAIL ==");
    $finish;
  end

endmodule

`default_nettype wire
